[hw/rtl/s8i_pkg.sv]
// Shared types, constants and helpers of the separable 8-tap interpolator.
// Depends on nothing; taken in by s8i_ram users, s8i_round and the top level.
`timescale 1ns / 1ps

package s8i_pkg;

	localparam int TAPS          = 8;
	localparam int HIST          = 7;
	localparam int FILTER_PREC   = 6;
	localparam int INTERNAL_OFFS = 8192;
	localparam int SAMPLE_W      = 14;
	localparam int VAL_W         = 16;
	localparam int LINE_W        = HIST * VAL_W;
	// horizontal sum: 8 x s8 x u14 minus offset
	localparam int HACC_W        = 26;
	// vertical sum: 8 x s8 x s16 plus rounding and offset
	localparam int VACC_W        = 28;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_COEFF_H   = 3'd0,
		CFG_COEFF_V   = 3'd1,
		CFG_BIT_DEPTH = 3'd2,
		CFG_FINAL     = 3'd3,
		CFG_WIDTH     = 3'd4,
		CFG_HEIGHT    = 3'd5
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MAC   = 5'b00010,
		ST_HSAT  = 5'b00100,
		ST_VLAST = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// controls of the output rounding stage
	typedef struct packed {
		logic       final_stage;
		logic [3:0] bd;
		logic [3:0] s2;
	} round_ctl_t;

	// saturate to signed 16 bits
	function automatic logic signed [VAL_W-1:0] sat16(input logic signed [VACC_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > VACC_W'(32767))
			r = 16'sh7fff;
		else if (v < -VACC_W'(32768))
			r = 16'sh8000;
		else
			r = v[VAL_W-1:0];
		return r;
	endfunction

	// pick signed tap k out of eight packed bytes
	function automatic logic signed [7:0] tap8(input logic [63:0] taps, input logic [2:0] k);
		logic signed [7:0] t;
		t = taps[8*k +: 8];
		return t;
	endfunction

endpackage

[hw/rtl/s8i_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module s8i_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// registered read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/s8i_round.sv]
// Output scaling of the vertical sum: final rounding and pixel clip, or
// intermediate shift with 16-bit saturation. Depends on s8i_pkg.
`timescale 1ns / 1ps

module s8i_round (
	input  logic signed [s8i_pkg::VACC_W-1:0] vacc,
	input  s8i_pkg::round_ctl_t               ctl,
	output logic        [s8i_pkg::VAL_W-1:0]  value
);
	import s8i_pkg::*;

	logic signed [VACC_W-1:0] rnd;
	logic signed [VACC_W-1:0] off;
	logic signed [VACC_W-1:0] fsum;
	logic signed [VACC_W-1:0] fsh;
	logic signed [VAL_W-1:0]  fsat;
	logic signed [VAL_W-1:0]  maxv;
	logic signed [VAL_W-1:0]  isat;

	// final path: round, add offset, shift, saturate, clip; intermediate path: shift, saturate
	always_comb begin
		rnd  = VACC_W'(1) <<< (ctl.s2 - 4'd1);
		off  = VACC_W'(INTERNAL_OFFS) <<< FILTER_PREC;
		fsum = vacc + rnd + off;
		fsh  = fsum >>> ctl.s2;
		fsat = sat16(fsh);
		maxv = VAL_W'((17'd1 << ctl.bd) - 17'd1);
		isat = sat16(vacc >>> FILTER_PREC);
		if (ctl.final_stage) begin
			if (fsat < 16'sd0)
				value = '0;
			else if (fsat > maxv)
				value = maxv;
			else
				value = fsat;
		end else begin
			value = isat;
		end
	end

endmodule

[hw/rtl/separable_8tap_subpel_interpolator.sv]
// Top level of the separable 8-tap sub-sample interpolator.
// Depends on s8i_pkg, s8i_ram (filtered line store) and s8i_round.
`timescale 1ns / 1ps

// Usage:
// - cfg_* writes one register (index 0 h taps, 1 v taps, 2 bit depth,
//   3 final stage, 4 block width, 5 block height); always ready. Write only
//   while the block is idle.
// - s_axis carries window samples of a (W+7)x(H+7) window in raster order,
//   starting 3 rows above and 3 columns left of the block.
// - m_axis carries one interpolated sample per window position past the
//   first 7 rows and columns; tlast marks the last sample of the block.
// Sequence: a sample in the first 7 columns of a window row only shifts the row
//   window. Any other sample runs one shared MAC pair over 8 taps and a read-
//   modify-write of its column entry in the line store, in the steps tap loop,
//   saturate and write back, and, when a result follows, last vertical tap and
//   output load. No new sample is taken until these steps are done.
// Stall: the output register holds a result while the next sample is taken;
//   only a second result waits for the receiver in the output load step.
// Reset: configuration and control registers return to defaults, counters go
//   to the window origin. The line store is not cleared; each block refills it in its top rows.
module separable_8tap_subpel_interpolator #(
	parameter int MAX_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [13:0] sample, [15:14] zero
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] value
	output logic        m_axis_tlast    // block_done
);
	import s8i_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + HIST + 1);

	// configuration registers
	logic [63:0] coeff_h_q;
	logic [63:0] coeff_v_q;
	logic [3:0]  bit_depth_q;
	logic        final_q;
	logic [4:0]  block_width_q;
	logic [7:0]  block_height_q;

	// control state
	state_t        state_q;
	logic [2:0]    k_q;
	logic [CW-1:0] column_q;
	logic [7:0]    row_q;
	logic          produce_s1;
	logic          m_valid_q;

	// payload
	logic [SAMPLE_W-1:0]      row_window [HIST];
	logic [SAMPLE_W-1:0]      sample_s1;
	logic [AW-1:0]            x_s1;
	logic                     last_s1;
	logic signed [HACC_W-1:0] hacc_q;
	logic signed [VACC_W-1:0] vacc_q;
	logic signed [VAL_W-1:0]  hv_q;
	logic [VAL_W-1:0]         m_data_q;
	logic                     m_last_q;

	// derived settings
	logic [3:0]    bd_eff;
	logic [3:0]    headroom;
	logic [2:0]    s1;
	logic [3:0]    s2;
	logic [CW-1:0] w_eff;
	logic [CW-1:0] wlim;
	logic [7:0]    h_eff;
	logic [7:0]    hlim;

	// counter logic
	logic [CW-1:0] col_pre;
	logic [CW-1:0] col_inc;
	logic [CW-1:0] col_nx;
	logic [7:0]    row_t;
	logic [7:0]    row_pre;
	logic [7:0]    row_inc;
	logic [7:0]    row_nx;
	logic          in_col;
	logic          prod_pre;
	logic          last_pre;
	logic [AW-1:0] x_pre;
	logic          acc_in;

	// datapath
	logic [SAMPLE_W-1:0]      tap_src [TAPS];
	logic signed [VAL_W-1:0]  v_src [TAPS];
	logic signed [22:0]       hprod;
	logic signed [23:0]       vprod;
	logic signed [HACC_W-1:0] hoff;
	logic signed [HACC_W-1:0] hsum;
	logic signed [HACC_W-1:0] hsh;
	logic signed [VAL_W-1:0]  hv;
	logic [LINE_W-1:0]        line_rd;
	logic [LINE_W-1:0]        line_wr;
	logic                     mem_we;
	logic                     mem_re;
	logic [VAL_W-1:0]         round_val;
	round_ctl_t               round_ctl;
	logic                     out_load;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc_in        = s_axis_tvalid && s_axis_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_h_q      <= '0;
			coeff_v_q      <= '0;
			bit_depth_q    <= 4'd10;
			final_q        <= 1'b1;
			block_width_q  <= 5'd8;
			block_height_q <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COEFF_H:   coeff_h_q      <= cfg_data;
				CFG_COEFF_V:   coeff_v_q      <= cfg_data;
				CFG_BIT_DEPTH: bit_depth_q    <= cfg_data[3:0];
				CFG_FINAL:     final_q        <= cfg_data[0];
				CFG_WIDTH:     block_width_q  <= cfg_data[4:0];
				CFG_HEIGHT:    block_height_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// effective sizes, depth and shifts
	always_comb begin
		if (bit_depth_q < 4'd8)
			bd_eff = 4'd8;
		else if (bit_depth_q > 4'd14)
			bd_eff = 4'd14;
		else
			bd_eff = bit_depth_q;
		headroom = (bd_eff < 4'd12) ? 4'(4'd14 - bd_eff) : 4'd2;
		s1       = 3'(4'd6 - headroom);
		s2       = 4'(4'd6 + headroom);
		if (int'(block_width_q) < 4)
			w_eff = CW'(4);
		else if (int'(block_width_q) > MAX_WIDTH)
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = CW'(block_width_q);
		wlim = w_eff + CW'(HIST);
		if (block_height_q == 8'd0)
			h_eff = 8'd1;
		else if (block_height_q > 8'd128)
			h_eff = 8'd128;
		else
			h_eff = block_height_q;
		hlim = h_eff + 8'(HIST);
	end

	// window position of the incoming sample and of the next one
	always_comb begin
		if (column_q >= wlim) begin
			col_pre = '0;
			row_t   = row_q + 8'd1;
		end else begin
			col_pre = column_q;
			row_t   = row_q;
		end
		row_pre = (row_t >= hlim) ? 8'd0 : row_t;
		col_inc = col_pre + CW'(1);
		row_inc = row_pre + 8'd1;
		if (col_inc == wlim) begin
			col_nx = '0;
			row_nx = (row_inc == hlim) ? 8'd0 : row_inc;
		end else begin
			col_nx = col_inc;
			row_nx = row_pre;
		end
		in_col   = (col_pre >= CW'(HIST));
		prod_pre = (row_pre >= 8'(HIST));
		last_pre = (row_pre == hlim - 8'd1) && (col_pre == wlim - CW'(1));
		x_pre    = AW'(col_pre - CW'(HIST));
	end

	// tap operands and the two multipliers
	always_comb begin
		for (int i = 0; i < HIST; i++) begin
			tap_src[i] = row_window[i];
			v_src[i]   = line_rd[VAL_W*i +: VAL_W];
		end
		tap_src[TAPS-1] = sample_s1;
		v_src[TAPS-1]   = hv_q;
		hprod = tap8(coeff_h_q, k_q) * signed'({1'b0, tap_src[k_q]});
		vprod = tap8(coeff_v_q, k_q) * v_src[k_q];
	end

	// horizontal result: remove offset, shift, saturate
	always_comb begin
		hoff = HACC_W'(INTERNAL_OFFS) <<< s1;
		hsum = hacc_q - hoff;
		hsh  = hsum >>> s1;
		hv   = sat16(VACC_W'(hsh));
	end

	// column entry shifted up by one row with the new filtered value on top
	always_comb begin
		for (int i = 0; i < HIST - 1; i++)
			line_wr[VAL_W*i +: VAL_W] = line_rd[VAL_W*(i+1) +: VAL_W];
		line_wr[VAL_W*(HIST-1) +: VAL_W] = hv;
	end

	// read at acceptance, write back after the tap loop; the next read is
	// only issued after the write, so no forwarding is needed
	assign mem_re = acc_in && in_col;
	assign mem_we = (state_q == ST_HSAT);

	s8i_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (x_s1),
		.wr_data (line_wr),
		.rd_en   (mem_re),
		.rd_addr (x_pre),
		.rd_data (line_rd)
	);

	assign round_ctl = '{final_stage: final_q, bd: bd_eff, s2: s2};

	s8i_round u_round (
		.vacc  (vacc_q),
		.ctl   (round_ctl),
		.value (round_val)
	);

	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			column_q   <= '0;
			row_q      <= '0;
			produce_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						column_q <= col_nx;
						row_q    <= row_nx;
						if (in_col) begin
							produce_s1 <= prod_pre;
							k_q        <= '0;
							state_q    <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					if (k_q == 3'(TAPS - 1))
						state_q <= ST_HSAT;
					else
						k_q <= k_q + 3'd1;
				end
				ST_HSAT: begin
					state_q <= produce_s1 ? ST_VLAST : ST_IDLE;
				end
				ST_VLAST: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc_in) begin
			sample_s1 <= s_axis_tdata[SAMPLE_W-1:0];
			x_s1      <= x_pre;
			last_s1   <= last_pre;
			hacc_q    <= '0;
			vacc_q    <= '0;
		end
		// margin samples only shift the row window
		if (acc_in && !in_col) begin
			for (int i = 0; i < HIST - 1; i++)
				row_window[i] <= row_window[i+1];
			row_window[HIST-1] <= s_axis_tdata[SAMPLE_W-1:0];
		end
		if (state_q == ST_MAC) begin
			hacc_q <= hacc_q + HACC_W'(hprod);
			if (k_q != 3'(TAPS - 1))
				vacc_q <= vacc_q + VACC_W'(vprod);
		end
		if (state_q == ST_HSAT) begin
			hv_q <= hv;
			for (int i = 0; i < HIST - 1; i++)
				row_window[i] <= row_window[i+1];
			row_window[HIST-1] <= sample_s1;
		end
		// last vertical tap uses the fresh horizontal value
		if (state_q == ST_VLAST)
			vacc_q <= vacc_q + VACC_W'(vprod);
		if (out_load) begin
			m_data_q <= round_val;
			m_last_q <= last_s1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	// line store is written only right after the full tap loop
	a_write_after_loop: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> $past(state_q == ST_MAC) && $past(k_q == 3'(TAPS - 1)))
		else $error("line store write outside the write-back step");

	// the tap loop runs all eight taps before leaving
	a_loop_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) && (k_q != 3'(TAPS - 1)) |=> (state_q == ST_MAC))
		else $error("tap loop left early");

	// results are loaded only for window rows below the top margin
	a_out_only_produce: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> produce_s1)
		else $error("result loaded for a margin row");

	// the column counter stays inside the window after each transaction
	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> (column_q < wlim))
		else $error("column counter beyond window width");

endmodule
